// ===== design/wialu_pkg.sv =====
package wialu_pkg;

   localparam int DATA_W    = 256;
   localparam int WORD_W    = 64;
   localparam int LIMB_W    = 32;
   localparam int NUM_LIMB  = DATA_W / LIMB_W;
   localparam int BYTE_W    = 8;
   localparam int NUM_BYTES = DATA_W / BYTE_W;
   localparam int SH_W      = 9;
   localparam int OP_W      = 5;
   localparam int DIV_STEPS = DATA_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 5'd0,
      OP_SUB     = 5'd1,
      OP_MUL     = 5'd2,
      OP_DIV     = 5'd3,
      OP_MOD     = 5'd4,
      OP_AND     = 5'd5,
      OP_OR      = 5'd6,
      OP_XOR     = 5'd7,
      OP_NOT     = 5'd8,
      OP_SHL     = 5'd9,
      OP_SHR     = 5'd10,
      OP_LT      = 5'd11,
      OP_GT      = 5'd12,
      OP_LE      = 5'd13,
      OP_GE      = 5'd14,
      OP_EQ      = 5'd15,
      OP_NE      = 5'd16,
      OP_ISZERO  = 5'd17,
      OP_GETBYTE = 5'd18,
      OP_SETBYTE = 5'd19
   } op_type;

   // One beat in the long-division chain; non-divide beats ride in aq.
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              is_mod;
      logic              div_err;
      logic              flag;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] aq;
   } div_beat_type;

endpackage

// ===== design/wide_integer_alu_256_top.sv =====
// 256-bit integer ALU. One operation enters per clock and its result leaves
// on rsp_valid, in issue order; busy is always low and the receiver cannot
// stall. Every result passes through the restoring divider:
// 256 stages, one quotient bit per stage, fed after a five-stage front end
// (input register, 32x32 partial products, three adder-tree levels) and an
// entry register. Every opcode takes the same path so results never reorder.
module wide_integer_alu_256_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [wialu_pkg::OP_W-1:0]   req_opcode,
   input  logic [wialu_pkg::WORD_W-1:0] req_a_word0,
   input  logic [wialu_pkg::WORD_W-1:0] req_a_word1,
   input  logic [wialu_pkg::WORD_W-1:0] req_a_word2,
   input  logic [wialu_pkg::WORD_W-1:0] req_a_word3,
   input  logic [wialu_pkg::WORD_W-1:0] req_b_word0,
   input  logic [wialu_pkg::WORD_W-1:0] req_b_word1,
   input  logic [wialu_pkg::WORD_W-1:0] req_b_word2,
   input  logic [wialu_pkg::WORD_W-1:0] req_b_word3,
   input  logic [wialu_pkg::SH_W-1:0]   req_shift_amount,
   output logic                         rsp_valid,
   output logic [wialu_pkg::WORD_W-1:0] rsp_result_word0,
   output logic [wialu_pkg::WORD_W-1:0] rsp_result_word1,
   output logic [wialu_pkg::WORD_W-1:0] rsp_result_word2,
   output logic [wialu_pkg::WORD_W-1:0] rsp_result_word3,
   output logic                         rsp_compare_flag,
   output logic                         rsp_divide_error
);
   import wialu_pkg::*;

   // Stage 1: input register
   logic               s1_valid_ff;
   logic [OP_W-1:0]    s1_op_ff;
   logic [DATA_W-1:0]  s1_a_ff, s1_b_ff;
   logic [SH_W-1:0]    s1_sh_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_op_ff <= req_opcode;
      s1_a_ff  <= {req_a_word3, req_a_word2, req_a_word1, req_a_word0};
      s1_b_ff  <= {req_b_word3, req_b_word2, req_b_word1, req_b_word0};
      s1_sh_ff <= req_shift_amount;
   end

   // Stage 2: simple ops, flags and 32x32 partial products
   logic [DATA_W-1:0]   res_in;
   logic                flag_in;
   logic                derr_in;
   logic                lt, eq;
   logic [7:0]          byte_pos;
   logic [2*LIMB_W-1:0] pp_in [NUM_LIMB][NUM_LIMB];
   logic [2*LIMB_W-1:0] pp_ff [NUM_LIMB][NUM_LIMB];
   logic                s2_valid_ff;
   logic [OP_W-1:0]     s2_op_ff;
   logic [DATA_W-1:0]   s2_a_ff, s2_b_ff, s2_res_ff;
   logic                s2_flag_ff, s2_derr_ff;

   always_comb begin
      lt       = (s1_a_ff < s1_b_ff);
      eq       = (s1_a_ff == s1_b_ff);
      byte_pos = {s1_sh_ff[4:0], 3'b000};
      res_in   = '0;
      flag_in  = 1'b0;
      derr_in  = 1'b0;
      case (op_type'(s1_op_ff))
         OP_ADD: res_in = s1_a_ff + s1_b_ff;
         OP_SUB: res_in = s1_a_ff - s1_b_ff;
         OP_DIV, OP_MOD: derr_in = (s1_b_ff == '0);
         OP_AND: res_in = s1_a_ff & s1_b_ff;
         OP_OR:  res_in = s1_a_ff | s1_b_ff;
         OP_XOR: res_in = s1_a_ff ^ s1_b_ff;
         OP_NOT: res_in = ~s1_a_ff;
         OP_SHL: res_in = s1_sh_ff[SH_W-1] ? '0 : (s1_a_ff << s1_sh_ff[SH_W-2:0]);
         OP_SHR: res_in = s1_sh_ff[SH_W-1] ? '0 : (s1_a_ff >> s1_sh_ff[SH_W-2:0]);
         OP_LT:  flag_in = lt;
         OP_GT:  flag_in = !lt && !eq;
         OP_LE:  flag_in = lt || eq;
         OP_GE:  flag_in = !lt;
         OP_EQ:  flag_in = eq;
         OP_NE:  flag_in = !eq;
         OP_ISZERO: flag_in = (s1_a_ff == '0);
         OP_GETBYTE: begin
            if (s1_sh_ff < SH_W'(NUM_BYTES)) begin
               res_in[BYTE_W-1:0] = s1_a_ff[byte_pos +: BYTE_W];
            end
         end
         OP_SETBYTE: begin
            res_in = s1_a_ff;
            if (s1_sh_ff < SH_W'(NUM_BYTES)) begin
               res_in[byte_pos +: BYTE_W] = s1_b_ff[BYTE_W-1:0];
            end
         end
         default: res_in = '0;
      endcase
   end

   // Form only the products that land in the low 256 bits
   always_comb begin
      for (int i = 0; i < NUM_LIMB; i++) begin
         for (int j = 0; j < NUM_LIMB; j++) begin
            if (i + j < NUM_LIMB) begin
               pp_in[i][j] = s1_a_ff[LIMB_W*i +: LIMB_W] * s1_b_ff[LIMB_W*j +: LIMB_W];
            end else begin
               pp_in[i][j] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_op_ff   <= s1_op_ff;
      s2_a_ff    <= s1_a_ff;
      s2_b_ff    <= s1_b_ff;
      s2_res_ff  <= res_in;
      s2_flag_ff <= flag_in;
      s2_derr_ff <= derr_in;
      pp_ff      <= pp_in;
   end

   // Stage 3: pack non-overlapping products into 16 rows, add pairwise
   logic [DATA_W-1:0] rows [2*NUM_LIMB];
   logic [DATA_W-1:0] sum8_in [NUM_LIMB];
   logic [DATA_W-1:0] sum8_ff [NUM_LIMB];
   logic [DATA_W-1:0] sum4_ff [NUM_LIMB/2];
   logic [DATA_W-1:0] sum2_ff [NUM_LIMB/4];

   always_comb begin
      for (int k = 0; k < 2*NUM_LIMB; k++) begin
         rows[k] = '0;
      end
      for (int i = 0; i < NUM_LIMB; i++) begin
         for (int j = 0; j < NUM_LIMB; j++) begin
            if (i + j < NUM_LIMB) begin
               rows[2*i + (j % 2)] = rows[2*i + (j % 2)]
                  | (DATA_W'(pp_ff[i][j]) << (LIMB_W*(i + j)));
            end
         end
      end
      for (int k = 0; k < NUM_LIMB; k++) begin
         sum8_in[k] = rows[2*k] + rows[2*k + 1];
      end
   end

   logic              s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic [OP_W-1:0]   s3_op_ff, s4_op_ff, s5_op_ff;
   logic [DATA_W-1:0] s3_a_ff, s4_a_ff, s5_a_ff;
   logic [DATA_W-1:0] s3_b_ff, s4_b_ff, s5_b_ff;
   logic [DATA_W-1:0] s3_res_ff, s4_res_ff, s5_res_ff;
   logic              s3_flag_ff, s4_flag_ff, s5_flag_ff;
   logic              s3_derr_ff, s4_derr_ff, s5_derr_ff;

   // Stages 3 to 5: adder tree, side data rides along
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
      sum8_ff <= sum8_in;
      for (int k = 0; k < NUM_LIMB/2; k++) begin
         sum4_ff[k] <= sum8_ff[2*k] + sum8_ff[2*k + 1];
      end
      for (int k = 0; k < NUM_LIMB/4; k++) begin
         sum2_ff[k] <= sum4_ff[2*k] + sum4_ff[2*k + 1];
      end
      s3_op_ff <= s2_op_ff;     s4_op_ff <= s3_op_ff;     s5_op_ff <= s4_op_ff;
      s3_a_ff <= s2_a_ff;       s4_a_ff <= s3_a_ff;       s5_a_ff <= s4_a_ff;
      s3_b_ff <= s2_b_ff;       s4_b_ff <= s3_b_ff;       s5_b_ff <= s4_b_ff;
      s3_res_ff <= s2_res_ff;   s4_res_ff <= s3_res_ff;   s5_res_ff <= s4_res_ff;
      s3_flag_ff <= s2_flag_ff; s4_flag_ff <= s3_flag_ff; s5_flag_ff <= s4_flag_ff;
      s3_derr_ff <= s2_derr_ff; s4_derr_ff <= s3_derr_ff; s5_derr_ff <= s4_derr_ff;
   end

   // Entry: final product add, load the divider beat
   div_beat_type entry_in;
   div_beat_type chain [DIV_STEPS+1];

   always_comb begin
      entry_in.valid   = s5_valid_ff && !reset;
      entry_in.is_div  = (op_type'(s5_op_ff) == OP_DIV);
      entry_in.is_mod  = (op_type'(s5_op_ff) == OP_MOD);
      entry_in.div_err = s5_derr_ff;
      entry_in.flag    = s5_flag_ff;
      entry_in.b       = s5_b_ff;
      entry_in.rem     = '0;
      if (entry_in.is_div || entry_in.is_mod) begin
         entry_in.aq = s5_a_ff;
      end else if (op_type'(s5_op_ff) == OP_MUL) begin
         entry_in.aq = sum2_ff[0] + sum2_ff[1];
      end else begin
         entry_in.aq = s5_res_ff;
      end
   end

   // Hold the entry beat; reset drops only its valid bit
   always_ff @(posedge clock) begin
      chain[0] <= entry_in;
   end

   // Divider: one quotient bit per stage
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      wialu_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (chain[g]),
         .beat_out (chain[g+1])
      );
   end

   // Output register: pick quotient (or non-divide result) or remainder, zero on divide error
   div_beat_type      last;
   logic [DATA_W-1:0] out_res_in;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_res_ff;
   logic              rsp_flag_ff, rsp_derr_ff;

   assign last = chain[DIV_STEPS];

   always_comb begin
      if (last.div_err) begin
         out_res_in = '0;
      end else if (last.is_mod) begin
         out_res_in = last.rem;
      end else begin
         out_res_in = last.aq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_res_ff  <= out_res_in;
      rsp_flag_ff <= last.flag;
      rsp_derr_ff <= last.div_err;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_word0 = rsp_res_ff[WORD_W-1:0];
   assign rsp_result_word1 = rsp_res_ff[2*WORD_W-1:WORD_W];
   assign rsp_result_word2 = rsp_res_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_result_word3 = rsp_res_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_compare_flag = rsp_flag_ff;
   assign rsp_divide_error = rsp_derr_ff;

   // A beat never carries both a compare answer and a divide error
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_compare_flag && rsp_divide_error))
      else $error("compare flag and divide error both set");

   // A divide error beat returns a zero result
   a_derr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_error) |-> (rsp_res_ff == '0))
      else $error("divide error with nonzero result");

   // A compare that holds returns zero result words
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_flag) |-> (rsp_res_ff == '0))
      else $error("compare result with nonzero words");

   // No result appears right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

// ===== design/wialu_div_step.sv =====
module wialu_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  wialu_pkg::div_beat_type beat_in,
   output wialu_pkg::div_beat_type beat_out
);
   import wialu_pkg::*;

   logic [DATA_W:0]  trial;
   logic [DATA_W:0]  diff;
   logic             fits;
   div_beat_type     beat_nx_in;
   div_beat_type     beat_ff;

   // Shift in the next dividend bit and try one subtract
   always_comb begin
      trial = {beat_in.rem, beat_in.aq[DATA_W-1]};
      diff  = trial - {1'b0, beat_in.b};
      fits  = (trial >= {1'b0, beat_in.b});
      beat_nx_in = beat_in;
      beat_nx_in.valid = beat_in.valid && !reset;
      if (beat_in.is_div || beat_in.is_mod) begin
         beat_nx_in.rem = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         beat_nx_in.aq  = {beat_in.aq[DATA_W-2:0], fits};
      end
   end

   // Advance the beat; reset drops only its valid bit
   always_ff @(posedge clock) begin
      beat_ff <= beat_nx_in;
   end

   assign beat_out = beat_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import wialu_pkg::*;

   localparam int LATENCY   = 263;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 1330;

   typedef struct {
      logic [4:0]   op;
      logic [255:0] a;
      logic [255:0] b;
      logic [8:0]   sh;
   } alu_cmd_type;

   typedef struct {
      logic [255:0] value;
      logic         cmp;
      logic         derr;
   } alu_res_type;

   logic clock, reset, start, busy;
   logic [OP_W-1:0]   req_opcode;
   logic [WORD_W-1:0] req_a_word0, req_a_word1, req_a_word2, req_a_word3;
   logic [WORD_W-1:0] req_b_word0, req_b_word1, req_b_word2, req_b_word3;
   logic [SH_W-1:0]   req_shift_amount;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_result_word0, rsp_result_word1;
   logic [WORD_W-1:0] rsp_result_word2, rsp_result_word3;
   logic              rsp_compare_flag, rsp_divide_error;

   alu_res_type pending_results[$];
   int       errors;
   int       beats_in;
   int       beats_out;
   int       idle_cycles;
   int       idle_pct;
   bit       op_seen[32];

   wide_integer_alu_256_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode),
      .req_a_word0(req_a_word0), .req_a_word1(req_a_word1),
      .req_a_word2(req_a_word2), .req_a_word3(req_a_word3),
      .req_b_word0(req_b_word0), .req_b_word1(req_b_word1),
      .req_b_word2(req_b_word2), .req_b_word3(req_b_word3),
      .req_shift_amount(req_shift_amount),
      .rsp_valid(rsp_valid),
      .rsp_result_word0(rsp_result_word0), .rsp_result_word1(rsp_result_word1),
      .rsp_result_word2(rsp_result_word2), .rsp_result_word3(rsp_result_word3),
      .rsp_compare_flag(rsp_compare_flag), .rsp_divide_error(rsp_divide_error)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // compute the expected ALU outcome
   function automatic alu_res_type alu_compute(alu_cmd_type c);
      alu_res_type  r;
      logic [511:0] prod;
      logic [255:0] rem, quo;
      logic         carry;
      int           pos;
      r.value = '0;
      r.cmp   = 1'b0;
      r.derr  = 1'b0;
      pos     = c.sh;
      case (c.op)
         OP_ADD: r.value = c.a + c.b;
         OP_SUB: r.value = c.a - c.b;
         OP_MUL: begin
            prod    = {256'd0, c.a} * {256'd0, c.b};
            r.value = prod[255:0];
         end
         OP_DIV, OP_MOD: begin
            if (c.b == '0) begin
               r.derr = 1'b1;
            end else begin
               // restoring long division, one bit per step
               rem = '0;
               quo = '0;
               for (int i = 255; i >= 0; i--) begin
                  carry = rem[255];
                  rem   = {rem[254:0], c.a[i]};
                  if (carry || rem >= c.b) begin
                     rem    = rem - c.b;
                     quo[i] = 1'b1;
                  end
               end
               r.value = (c.op == OP_DIV) ? quo : rem;
            end
         end
         OP_AND:    r.value = c.a & c.b;
         OP_OR:     r.value = c.a | c.b;
         OP_XOR:    r.value = c.a ^ c.b;
         OP_NOT:    r.value = ~c.a;
         OP_SHL:    r.value = (pos >= 256) ? '0 : c.a << pos;
         OP_SHR:    r.value = (pos >= 256) ? '0 : c.a >> pos;
         OP_LT:     r.cmp = c.a < c.b;
         OP_GT:     r.cmp = c.a > c.b;
         OP_LE:     r.cmp = c.a <= c.b;
         OP_GE:     r.cmp = c.a >= c.b;
         OP_EQ:     r.cmp = c.a == c.b;
         OP_NE:     r.cmp = c.a != c.b;
         OP_ISZERO: r.cmp = c.a == '0;
         OP_GETBYTE: begin
            if (pos < 32) r.value[7:0] = c.a[pos*8 +: 8];
         end
         OP_SETBYTE: begin
            r.value = c.a;
            if (pos < 32) r.value[pos*8 +: 8] = c.b[7:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   // operand with a random shape: zero, all ones, one bit, small, low bits cleared or full random
   function automatic logic [255:0] rand_operand();
      logic [255:0] v;
      int           kind;
      kind = $urandom_range(0, 9);
      v    = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      case (kind)
         0: v = '0;
         1: v = '1;
         2: v = 256'd1 << $urandom_range(0, 255);
         3: v = v >> $urandom_range(0, 255);
         4: v = v & ({256{1'b1}} << $urandom_range(0, 255));
         default: ;
      endcase
      return v;
   endfunction

   // drive one command beat and hold it until accepted
   task automatic issue(alu_cmd_type c, bit use_typed, alu_res_type typed);
      alu_res_type predicted;
      predicted = alu_compute(c);
      if (use_typed && (predicted.value !== typed.value || predicted.cmp !== typed.cmp
                        || predicted.derr !== typed.derr)) begin
         $display("%0t table row disagrees with predictor: op %0d exp %h/%b/%b got %h/%b/%b",
                  $time, c.op, typed.value, typed.cmp, typed.derr,
                  predicted.value, predicted.cmp, predicted.derr);
         errors++;
      end
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_opcode       <= c.op;
      {req_a_word3, req_a_word2, req_a_word1, req_a_word0} <= c.a;
      {req_b_word3, req_b_word2, req_b_word1, req_b_word0} <= c.b;
      req_shift_amount <= c.sh;
      do @(posedge clock); while (busy);
      pending_results.push_back(use_typed ? typed : predicted);
      op_seen[c.op] = 1'b1;
      beats_in++;
      @(negedge clock);
   endtask

   // compare each result beat against the oldest expectation
   always @(posedge clock) begin
      alu_res_type exp_r;
      logic [255:0] got;
      if (!reset && rsp_valid) begin
         beats_out++;
         got = {rsp_result_word3, rsp_result_word2, rsp_result_word1, rsp_result_word0};
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result beat: got %h", $time, got);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (got !== exp_r.value) begin
               $display("%0t result mismatch: exp %h got %h", $time, exp_r.value, got);
               errors++;
            end
            if (rsp_compare_flag !== exp_r.cmp) begin
               $display("%0t compare_flag mismatch: exp %b got %b",
                        $time, exp_r.cmp, rsp_compare_flag);
               errors++;
            end
            if (rsp_divide_error !== exp_r.derr) begin
               $display("%0t divide_error mismatch: exp %b got %b",
                        $time, exp_r.derr, rsp_divide_error);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles with no beat accepted on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // directed table: zero, ones, carries, divide by zero, shift and byte edges, compares, an unused opcode
   localparam logic [255:0] ONES = {256{1'b1}};
   localparam logic [255:0] ONE  = 256'd1;

   initial begin
      alu_cmd_type dir_cmd[25];
      bit          dir_typed[25];
      alu_res_type dir_res[25];
      alu_res_type no_res;
      alu_cmd_type c;
      int          n;
      int          wait_cnt;
      int          ops_hit;

      errors = 0; beats_in = 0; beats_out = 0; idle_cycles = 0; idle_pct = 0;
      start = 1'b0; req_opcode = '0; req_shift_amount = '0;
      {req_a_word3, req_a_word2, req_a_word1, req_a_word0} = '0;
      {req_b_word3, req_b_word2, req_b_word1, req_b_word0} = '0;
      no_res = '{value: '0, cmp: 1'b0, derr: 1'b0};
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      n = 0;
      dir_cmd[n] = '{OP_ADD, ONES, ONE, 0};      dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_SUB, '0, ONE, 0};        dir_typed[n] = 1;
      dir_res[n] = '{ONES, 0, 0}; n++;
      dir_cmd[n] = '{OP_MUL, ONES, ONES, 0};     dir_typed[n] = 1;
      dir_res[n] = '{ONE, 0, 0}; n++;
      dir_cmd[n] = '{OP_DIV, ONES, '0, 0};       dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 1}; n++;
      dir_cmd[n] = '{OP_MOD, ONES, '0, 0};       dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 1}; n++;
      dir_cmd[n] = '{OP_DIV, ONES, ONE, 0};      dir_typed[n] = 1;
      dir_res[n] = '{ONES, 0, 0}; n++;
      dir_cmd[n] = '{OP_MOD, ONES, 256'd10, 0};  dir_typed[n] = 0; n++;
      dir_cmd[n] = '{OP_AND, ONES, '0, 0};       dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_OR, '0, ONES, 0};        dir_typed[n] = 1;
      dir_res[n] = '{ONES, 0, 0}; n++;
      dir_cmd[n] = '{OP_XOR, ONES, ONES, 0};     dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_NOT, '0, ONES, 0};       dir_typed[n] = 1;
      dir_res[n] = '{ONES, 0, 0}; n++;
      dir_cmd[n] = '{OP_SHL, ONES, '0, 256};     dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_SHR, ONES, '0, 511};     dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_SHL, ONES, '0, 255};     dir_typed[n] = 0; n++;
      dir_cmd[n] = '{OP_SHR, ONES, '0, 64};      dir_typed[n] = 0; n++;
      dir_cmd[n] = '{OP_LT, '0, ONES, 0};        dir_typed[n] = 1;
      dir_res[n] = '{'0, 1, 0}; n++;
      dir_cmd[n] = '{OP_GT, '0, ONES, 0};        dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_LE, ONES, ONES, 0};      dir_typed[n] = 1;
      dir_res[n] = '{'0, 1, 0}; n++;
      dir_cmd[n] = '{OP_GE, ONE, ONES, 0};       dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_EQ, ONES, ONES, 0};      dir_typed[n] = 1;
      dir_res[n] = '{'0, 1, 0}; n++;
      dir_cmd[n] = '{OP_NE, ONES, ONES, 0};      dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{OP_ISZERO, '0, ONES, 0};    dir_typed[n] = 1;
      dir_res[n] = '{'0, 1, 0}; n++;
      dir_cmd[n] = '{OP_GETBYTE, ONES, '0, 31};  dir_typed[n] = 1;
      dir_res[n] = '{256'hFF, 0, 0}; n++;
      dir_cmd[n] = '{OP_SETBYTE, '0, ONES, 32};  dir_typed[n] = 1;
      dir_res[n] = '{'0, 0, 0}; n++;
      dir_cmd[n] = '{5'd31, ONES, ONES, 0};      dir_typed[n] = 1;
      dir_res[n] = no_res; n++;

      // walk the table back to back
      for (int i = 0; i < n; i++) issue(dir_cmd[i], dir_typed[i], dir_res[i]);
      start <= 1'b0;

      // pause until the pipeline drains
      wait_cnt = 0;
      while (pending_results.size() != 0 && wait_cnt < 10 * LATENCY) begin
         @(negedge clock);
         wait_cnt++;
      end

      // random part across sender idling phases
      for (int i = 0; i < N_RANDOM; i++) begin
         case ((i * 4) / N_RANDOM)
            0: idle_pct = 0;
            1: idle_pct = 67;
            2: idle_pct = 36;
            default: idle_pct = (i % 200 < 100) ? 0 : 67;
         endcase
         c.op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                            : 5'($urandom_range(0, 19));
         c.a  = rand_operand();
         c.b  = ($urandom_range(0, 3) == 0) ? c.a : rand_operand();
         c.sh = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 40));
         issue(c, 1'b0, no_res);
      end
      start <= 1'b0;

      // wait for the tail, then a little more
      wait_cnt = 0;
      while (pending_results.size() != 0 && wait_cnt < 10 * LATENCY) begin
         @(negedge clock);
         wait_cnt++;
      end
      repeat (LATENCY + 10) @(negedge clock);

      ops_hit = 0;
      for (int k = 0; k < 32; k++) begin
         if (op_seen[k]) ops_hit++;
      end
      $display("Ran %0d commands, %0d result beats checked.", beats_in, beats_out);
      $display("Opcode values exercised: %0d of 32, under several sender idle rates.",
               ops_hit);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/wialu_pkg.sv
design/wialu_div_step.sv
design/wide_integer_alu_256_top.sv
test/tb.sv
